// ===== rtl/pmat_pkg.sv =====
// Shared types and constants for the power mode acknowledgement tracker.
// No dependencies; imported by every module of the block.
package pmat_pkg;

  // Number of tracked agents (1 to 32)
  localparam int AGENTS = 4;

  localparam int CMD_W   = 2;
  localparam int ID_W    = 6;
  localparam int GEN_W   = 32;
  localparam int FACTS_W = 9;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_REQUEST    = 2'd0,
    CMD_IDENTITY   = 2'd1,
    CMD_DISCONNECT = 2'd2,
    CMD_ACK        = 2'd3
  } cmd_t;

  // Bit positions in the radio facts word
  localparam int FACT_TX_EN         = 0;
  localparam int FACT_BLE_SCAN      = 1;
  localparam int FACT_WIFI_PAUSED   = 2;
  localparam int FACT_BLE_QUIESCED  = 3;
  localparam int FACT_WIFI_QUIESCED = 4;
  localparam int FACT_BLE_ACTIVE    = 5;
  localparam int FACT_WIFI_ACTIVE   = 6;
  localparam int FACT_READY         = 7;
  localparam int FACT_TX_RESTORED   = 8;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming word
    logic commit;  // update state and load the result register
  } dp_ctrl_t;

endpackage

// ===== rtl/power_mode_ack_tracker.sv =====
// Top level of the power mode acknowledgement tracker.
// Depends on pmat_pkg, pmat_ctrl and pmat_dp.
//
//   Channel  | Handshake           | Word
//   ---------+---------------------+-----------------------------------------------
//   input    | in_valid / in_stall | cmd, agent_id, want_quiet, ack_gen,
//            |                     | switch_ok, commands_enabled, radio_facts
//   output   | out_valid/out_stall | accepted, all_converged, generation_now,
//            |                     | quiet_now
//
// Each word is captured in the idle state, then the controller's execute state
// updates the tracker and loads the result register; one result per word.
// Reset (rst, synchronous) returns the normal mode, generation zero and no agents.
// A held result keeps execute waiting and so also stalls the input; the next word is taken once execute is done.
module power_mode_ack_tracker
  import pmat_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [ID_W-1:0]    agent_id,
  input  logic               want_quiet,
  input  logic [GEN_W-1:0]   ack_gen,
  input  logic               switch_ok,
  input  logic               commands_enabled,
  input  logic [FACTS_W-1:0] radio_facts,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               accepted,
  output logic               all_converged,
  output logic [GEN_W-1:0]   generation_now,
  output logic               quiet_now
);

  dp_ctrl_t dp_ctrl;

  pmat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_ctrl   (dp_ctrl)
  );

  pmat_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .dp_ctrl          (dp_ctrl),
    .cmd              (cmd),
    .agent_id         (agent_id),
    .want_quiet       (want_quiet),
    .ack_gen          (ack_gen),
    .switch_ok        (switch_ok),
    .commands_enabled (commands_enabled),
    .radio_facts      (radio_facts),
    .accepted         (accepted),
    .all_converged    (all_converged),
    .generation_now   (generation_now),
    .quiet_now        (quiet_now)
  );

endmodule

// ===== rtl/pmat_ctrl.sv =====
// Controller for the power mode acknowledgement tracker: handshakes and sequencing.
// Depends on pmat_pkg.
module pmat_ctrl
  import pmat_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_ctrl_t dp_ctrl
);

  state_t state;
  state_t state_next;
  logic   out_free;

  // Result register can take a new word
  assign out_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall       = 1'b1;
    dp_ctrl.load   = 1'b0;
    dp_ctrl.commit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall     = 1'b0;
        dp_ctrl.load = in_valid;
      end
      ST_EXEC: begin
        dp_ctrl.commit = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (dp_ctrl.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_commit_gives_result: assert property (@(posedge clk) disable iff (rst)
    dp_ctrl.commit |=> out_valid)
    else $error("committed word did not reach the result register");

  a_wait_on_full_output: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && out_valid && out_stall) |=> (state == ST_EXEC && !dp_ctrl.load))
    else $error("controller left execute while the result was still held");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result word was dropped");
`endif

endmodule

// ===== rtl/pmat_dp.sv =====
// Datapath for the power mode acknowledgement tracker: mode, generation, agent flags.
// Depends on pmat_pkg; sequenced by pmat_ctrl.
module pmat_dp
  import pmat_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_ctrl_t           dp_ctrl,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [ID_W-1:0]    agent_id,
  input  logic               want_quiet,
  input  logic [GEN_W-1:0]   ack_gen,
  input  logic               switch_ok,
  input  logic               commands_enabled,
  input  logic [FACTS_W-1:0] radio_facts,
  output logic               accepted,
  output logic               all_converged,
  output logic [GEN_W-1:0]   generation_now,
  output logic               quiet_now
);

  // Captured input word
  cmd_t               cmd_q;
  logic [ID_W-1:0]    id_q;
  logic               quiet_q;
  logic [GEN_W-1:0]   ack_gen_q;
  logic               trans_ok_q;
  logic               cmds_en_q;
  logic [FACTS_W-1:0] facts_q;

  // Tracker state
  logic               target_quiet;
  logic [GEN_W-1:0]   generation_count;
  logic [AGENTS-1:0]  connected;
  logic [AGENTS-1:0]  acked;

  logic               target_quiet_next;
  logic [GEN_W-1:0]   generation_count_next;
  logic [AGENTS-1:0]  connected_next;
  logic [AGENTS-1:0]  acked_next;
  logic               accepted_next;

  logic [AGENTS-1:0]  sel;
  logic               id_ok;
  logic [GEN_W-1:0]   gen_inc;
  logic               quiet_facts_ok;
  logic               normal_facts_ok;
  logic               ack_ok;

  // Input capture
  always_ff @(posedge clk) begin
    if (dp_ctrl.load) begin
      cmd_q      <= cmd_t'(cmd);
      id_q       <= agent_id;
      quiet_q    <= want_quiet;
      ack_gen_q  <= ack_gen;
      trans_ok_q <= switch_ok;
      cmds_en_q  <= commands_enabled;
      facts_q    <= radio_facts;
    end
  end

  // Agent select, empty when the id is out of range
  always_comb begin
    for (int i = 0; i < AGENTS; i++) begin
      sel[i] = (id_q == ID_W'(i));
    end
  end
  assign id_ok = (id_q < ID_W'(AGENTS));

  // Next generation, skipping zero on wrap
  assign gen_inc = (generation_count == {GEN_W{1'b1}}) ? GEN_W'(1)
                                                        : generation_count + GEN_W'(1);

  // Mode-specific radio checks
  assign quiet_facts_ok = !facts_q[FACT_TX_EN] && !facts_q[FACT_BLE_SCAN] &&
                          facts_q[FACT_WIFI_PAUSED] && facts_q[FACT_BLE_QUIESCED] &&
                          facts_q[FACT_WIFI_QUIESCED] && !facts_q[FACT_BLE_ACTIVE] &&
                          !facts_q[FACT_WIFI_ACTIVE] && facts_q[FACT_READY];
  assign normal_facts_ok = facts_q[FACT_READY] && facts_q[FACT_TX_RESTORED];

  assign ack_ok = trans_ok_q && (ack_gen_q == generation_count) &&
                  (quiet_q == target_quiet) && cmds_en_q &&
                  (quiet_q ? quiet_facts_ok : normal_facts_ok);

  // Command execution
  always_comb begin
    target_quiet_next     = target_quiet;
    generation_count_next = generation_count;
    connected_next        = connected;
    acked_next            = acked;
    accepted_next         = 1'b0;
    unique case (cmd_q)
      CMD_REQUEST: begin
        if (quiet_q != target_quiet) begin
          target_quiet_next     = quiet_q;
          generation_count_next = gen_inc;
          acked_next            = '0;
          accepted_next         = 1'b1;
        end
      end
      CMD_IDENTITY: begin
        connected_next = connected | sel;
        acked_next     = acked & ~sel;
      end
      CMD_DISCONNECT: begin
        connected_next = connected & ~sel;
        acked_next     = acked & ~sel;
      end
      CMD_ACK: begin
        connected_next = connected | sel;
        acked_next     = ack_ok ? (acked | sel) : (acked & ~sel);
        accepted_next  = ack_ok && id_ok;
      end
      default: begin
        accepted_next = 1'b0;
      end
    endcase
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      target_quiet     <= 1'b0;
      generation_count <= '0;
      connected        <= '0;
      acked            <= '0;
    end else if (dp_ctrl.commit) begin
      target_quiet     <= target_quiet_next;
      generation_count <= generation_count_next;
      connected        <= connected_next;
      acked            <= acked_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (dp_ctrl.commit) begin
      accepted       <= accepted_next;
      all_converged  <= &(connected_next & acked_next);
      generation_now <= generation_count_next;
      quiet_now      <= target_quiet_next;
    end
  end

`ifndef SYNTHESIS
  a_acked_implies_connected: assert property (@(posedge clk) disable iff (rst)
    (acked & ~connected) == '0)
    else $error("agent acked while not connected");

  a_gen_holds_without_commit: assert property (@(posedge clk) disable iff (rst)
    !dp_ctrl.commit |=> $stable(generation_count) && $stable(target_quiet))
    else $error("tracker state moved without a commit");

  a_quiet_needs_generation: assert property (@(posedge clk) disable iff (rst)
    target_quiet |-> generation_count != '0)
    else $error("quiet mode with a zero generation");
`endif

endmodule
